// ----- hw/rtl/liang_barsky_line_clipper_assert.svh -----
// assertion helpers shared by the clipper rtl
// each check is sampled on clk and disabled while rst_n is low
`ifndef LIANG_BARSKY_LINE_CLIPPER_ASSERT_SVH
`define LIANG_BARSKY_LINE_CLIPPER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define LBC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lbc check failed");

`define LBC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lbc check failed");

`else

`define LBC_ASSERT_IMP(lbl, ante, cons)

`define LBC_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ----- hw/rtl/lbc_pkg.sv -----
package lbc_pkg;

  localparam int COORD_BITS_DEF  = 16;
  localparam int T_FRAC_BITS_DEF = 16;
  localparam int NUM_EDGES       = 4;
  localparam int CFG_IDX_W       = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_XMIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_YMIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_XMAX = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_YMAX = 2'd3;

  // window after reset
  localparam int XMIN_RST = 0;
  localparam int YMIN_RST = 0;
  localparam int XMAX_RST = 639;
  localparam int YMAX_RST = 479;

endpackage

// ----- hw/rtl/liang_barsky_line_clipper.sv -----
// channel | direction | handshake          | payload
// cfg     | in        | cfg_we             | cfg_index, cfg_wdata
// in      | in        | in_valid/in_stall  | in_start_x, in_start_y, in_end_x, in_end_y
// out     | out       | out_valid/out_stall| out_visible, out_clip_x0/y0/x1/y1
//
// one segment per cycle sustained while out_stall is low; the registered stages are
// edge setup, one divider stage per fraction bit, t select, multiply and output
// every stage holds its transaction while the stage after it is full and stalled
// rst_n is synchronous: valid bits clear and the window returns to 0,0 .. 639,479
`include "liang_barsky_line_clipper_assert.svh"

module liang_barsky_line_clipper #(
  parameter int COORD_BITS  = lbc_pkg::COORD_BITS_DEF,
  parameter int T_FRAC_BITS = lbc_pkg::T_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [lbc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [COORD_BITS-1:0]              cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [COORD_BITS-1:0]       in_start_x,
  input  logic signed [COORD_BITS-1:0]       in_start_y,
  input  logic signed [COORD_BITS-1:0]       in_end_x,
  input  logic signed [COORD_BITS-1:0]       in_end_y,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_visible,
  output logic signed [COORD_BITS-1:0]       out_clip_x0,
  output logic signed [COORD_BITS-1:0]       out_clip_y0,
  output logic signed [COORD_BITS-1:0]       out_clip_x1,
  output logic signed [COORD_BITS-1:0]       out_clip_y1
);

  localparam int C      = COORD_BITS;
  localparam int T      = T_FRAC_BITS;
  localparam int E      = lbc_pkg::NUM_EDGES;
  localparam int TW     = T + 2;
  localparam int SIDE_W = 4 * C + 21;

  // window registers
  logic signed [C-1:0] win_xmin_r, win_ymin_r, win_xmax_r, win_ymax_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_xmin_r <= C'(lbc_pkg::XMIN_RST);
      win_ymin_r <= C'(lbc_pkg::YMIN_RST);
      win_xmax_r <= C'(lbc_pkg::XMAX_RST);
      win_ymax_r <= C'(lbc_pkg::YMAX_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        lbc_pkg::CFG_XMIN: win_xmin_r <= cfg_wdata;
        lbc_pkg::CFG_YMIN: win_ymin_r <= cfg_wdata;
        lbc_pkg::CFG_XMAX: win_xmax_r <= cfg_wdata;
        lbc_pkg::CFG_YMAX: win_ymax_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage handshake chain, output side first
  logic en_out, en3, en2, en1;
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic div_in_stall, div_out_valid, div_out_stall;

  assign en_out        = !out_valid_r || !out_stall;
  assign en3           = !v3_r || en_out;
  assign en2           = !v2_r || en3;
  assign div_out_stall = !en2;
  assign en1           = !v1_r || !div_in_stall;
  assign in_stall      = !en1;

  // stage 1: edge p/q pairs, magnitudes and case flags
  logic signed [C:0] x0e, y0e, dx, dy;
  logic signed [C:0] p [E];
  logic signed [C:0] q [E];
  logic [E-1:0][C:0] num_nxt, den_nxt;
  logic [E-1:0]      ent_f, ext_f, gt_f, eq_f, rej_f;
  logic [C:0]        mdx, mdy;
  logic [SIDE_W-1:0] side1_nxt;

  always_comb begin
    x0e  = {in_start_x[C-1], in_start_x};
    y0e  = {in_start_y[C-1], in_start_y};
    dx   = {in_end_x[C-1], in_end_x} - x0e;
    dy   = {in_end_y[C-1], in_end_y} - y0e;
    p[0] = -dx;
    q[0] = x0e - {win_xmin_r[C-1], win_xmin_r};
    p[1] = dx;
    q[1] = {win_xmax_r[C-1], win_xmax_r} - x0e;
    p[2] = -dy;
    q[2] = y0e - {win_ymin_r[C-1], win_ymin_r};
    p[3] = dy;
    q[3] = {win_ymax_r[C-1], win_ymax_r} - y0e;
    for (int i = 0; i < E; i++) begin
      logic [C:0] mq;
      logic [C:0] mp;
      logic       pz;
      mq = q[i][C] ? (C+1)'(-q[i]) : (C+1)'(q[i]);
      mp = p[i][C] ? (C+1)'(-p[i]) : (C+1)'(p[i]);
      pz = (p[i] == '0);
      // parallel and outside, or leaving before the start
      rej_f[i] = q[i][C] && !p[i][C];
      ent_f[i] = p[i][C] && (q[i][C] || q[i] == '0);
      ext_f[i] = !pz && !p[i][C] && !q[i][C];
      gt_f[i]  = mq > mp;
      eq_f[i]  = mq == mp;
      num_nxt[i] = (gt_f[i] || eq_f[i]) ? '0 : mq;
      den_nxt[i] = mp;
    end
    mdx = dx[C] ? (C+1)'(-dx) : (C+1)'(dx);
    mdy = dy[C] ? (C+1)'(-dy) : (C+1)'(dy);
    side1_nxt = {in_start_x, in_start_y, mdx, mdy, dx[C], dy[C],
                 ent_f, ext_f, gt_f, eq_f, |rej_f};
  end

  logic [E-1:0][C:0] num1_r, den1_r;
  logic [SIDE_W-1:0] side1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      num1_r  <= num_nxt;
      den1_r  <= den_nxt;
      side1_r <= side1_nxt;
    end
  end

  // pipelined q/p ratios
  logic [E-1:0][T-1:0] div_quo;
  logic [SIDE_W-1:0]   div_side;

  lbc_div_pipe #(
    .COORD_BITS  (C),
    .T_FRAC_BITS (T),
    .SIDE_W      (SIDE_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v1_r),
    .in_stall  (div_in_stall),
    .in_num    (num1_r),
    .in_den    (den1_r),
    .in_side   (side1_r),
    .out_valid (div_out_valid),
    .out_stall (div_out_stall),
    .out_quo   (div_quo),
    .out_side  (div_side)
  );

  logic [C-1:0] d_x0, d_y0;
  logic [C:0]   d_mdx, d_mdy;
  logic         d_sdx, d_sdy, d_rej;
  logic [E-1:0] d_ent, d_ext, d_gt, d_eq;

  assign {d_x0, d_y0, d_mdx, d_mdy, d_sdx, d_sdy,
          d_ent, d_ext, d_gt, d_eq, d_rej} = div_side;

  // stage 2: t_enter is the largest entering ratio, t_exit the smallest exiting one
  logic [TW-1:0] t_one, t_en, t_ex;
  logic [TW-1:0] cand [E];
  logic          vis_nxt;

  always_comb begin
    t_one = TW'(1) << T;
    t_en  = '0;
    t_ex  = t_one;
    for (int i = 0; i < E; i++) begin
      // a ratio above one is kept as one lsb past 1.0
      if (d_gt[i]) cand[i] = t_one + TW'(1);
      else if (d_eq[i]) cand[i] = t_one;
      else cand[i] = {2'b00, div_quo[i]};
    end
    for (int i = 0; i < E; i++) begin
      if (d_ent[i] && cand[i] > t_en) t_en = cand[i];
      if (d_ext[i] && cand[i] < t_ex) t_ex = cand[i];
    end
    vis_nxt = !d_rej && (t_en < t_ex);
  end

  logic         vis2_r, sdx2_r, sdy2_r;
  logic [T:0]   ten2_r, tex2_r;
  logic [C-1:0] x02_r, y02_r;
  logic [C:0]   mdx2_r, mdy2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      vis2_r <= vis_nxt;
      ten2_r <= t_en[T:0];
      tex2_r <= t_ex[T:0];
      x02_r  <= d_x0;
      y02_r  <= d_y0;
      mdx2_r <= d_mdx;
      mdy2_r <= d_mdy;
      sdx2_r <= d_sdx;
      sdy2_r <= d_sdy;
    end
  end

  // stage 3: |delta| * t, fraction bits dropped (truncation toward zero)
  logic [C+T+1:0] mul_x0, mul_y0, mul_x1, mul_y1;

  assign mul_x0 = (C+T+2)'(mdx2_r) * (C+T+2)'(ten2_r);
  assign mul_y0 = (C+T+2)'(mdy2_r) * (C+T+2)'(ten2_r);
  assign mul_x1 = (C+T+2)'(mdx2_r) * (C+T+2)'(tex2_r);
  assign mul_y1 = (C+T+2)'(mdy2_r) * (C+T+2)'(tex2_r);

  logic         vis3_r, sdx3_r, sdy3_r;
  logic [C:0]   px0_r, py0_r, px1_r, py1_r;
  logic [C-1:0] x03_r, y03_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      vis3_r <= vis2_r;
      px0_r  <= mul_x0[C+T:T];
      py0_r  <= mul_y0[C+T:T];
      px1_r  <= mul_x1[C+T:T];
      py1_r  <= mul_y1[C+T:T];
      x03_r  <= x02_r;
      y03_r  <= y02_r;
      sdx3_r <= sdx2_r;
      sdy3_r <= sdy2_r;
    end
  end

  // stage 4: start +/- product, zeros when the segment is not visible
  logic [C:0] xb, yb, sx0, sy0, sx1, sy1;

  always_comb begin
    xb  = {x03_r[C-1], x03_r};
    yb  = {y03_r[C-1], y03_r};
    sx0 = sdx3_r ? xb - px0_r : xb + px0_r;
    sx1 = sdx3_r ? xb - px1_r : xb + px1_r;
    sy0 = sdy3_r ? yb - py0_r : yb + py0_r;
    sy1 = sdy3_r ? yb - py1_r : yb + py1_r;
  end

  logic         vis_out_r;
  logic [C-1:0] cx0_r, cy0_r, cx1_r, cy1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_out) begin
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      vis_out_r <= vis3_r;
      cx0_r     <= vis3_r ? sx0[C-1:0] : '0;
      cy0_r     <= vis3_r ? sy0[C-1:0] : '0;
      cx1_r     <= vis3_r ? sx1[C-1:0] : '0;
      cy1_r     <= vis3_r ? sy1[C-1:0] : '0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_visible = vis_out_r;
  assign out_clip_x0 = cx0_r;
  assign out_clip_y0 = cy0_r;
  assign out_clip_x1 = cx1_r;
  assign out_clip_y1 = cy1_r;

  // checks
  `LBC_ASSERT_IMP(a_vis_order, v2_r && vis2_r, ten2_r < tex2_r)
  `LBC_ASSERT_IMP(a_hidden_zero, out_valid_r && !vis_out_r,
                  cx0_r == '0 && cy0_r == '0 && cx1_r == '0 && cy1_r == '0)
  `LBC_ASSERT_NXT(a_accept_lands, in_valid && !in_stall, v1_r)
  `LBC_ASSERT_NXT(a_mul_hold, v3_r && !en3, v3_r && $stable(px1_r) && $stable(vis3_r))

endmodule

// ----- hw/rtl/lbc_div_pipe.sv -----
module lbc_div_pipe #(
  parameter int COORD_BITS  = lbc_pkg::COORD_BITS_DEF,
  parameter int T_FRAC_BITS = lbc_pkg::T_FRAC_BITS_DEF,
  parameter int SIDE_W      = 1
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_valid,
  output logic                                          in_stall,
  input  logic [lbc_pkg::NUM_EDGES-1:0][COORD_BITS:0]   in_num,
  input  logic [lbc_pkg::NUM_EDGES-1:0][COORD_BITS:0]   in_den,
  input  logic [SIDE_W-1:0]                             in_side,
  output logic                                          out_valid,
  input  logic                                          out_stall,
  output logic [lbc_pkg::NUM_EDGES-1:0][T_FRAC_BITS-1:0] out_quo,
  output logic [SIDE_W-1:0]                             out_side
);

  localparam int C = COORD_BITS;
  localparam int T = T_FRAC_BITS;
  localparam int E = lbc_pkg::NUM_EDGES;

  // one restoring quotient bit per stage, four lanes side by side
  logic [T-1:0]                 v_r;
  logic [T-1:0]                 en;
  logic [T-1:0][E-1:0][C:0]     rem_r;
  logic [T-1:0][E-1:0][C:0]     den_r;
  logic [T-1:0][E-1:0][T-1:0]   quo_r;
  logic [T-1:0][SIDE_W-1:0]     side_r;

  always_comb begin
    en[T-1] = !v_r[T-1] || !out_stall;
    for (int k = T - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_stall = !en[0];

  for (genvar k = 0; k < T; k++) begin : g_stage
    logic                    v_in;
    logic [E-1:0][C:0]       rem_in;
    logic [E-1:0][C:0]       den_in;
    logic [E-1:0][T-1:0]     quo_in;
    logic [SIDE_W-1:0]       side_in;
    logic [E-1:0][C:0]       rem_nxt;
    logic [E-1:0][T-1:0]     quo_nxt;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = in_num;
      assign den_in  = in_den;
      assign quo_in  = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign den_in  = den_r[k-1];
      assign quo_in  = quo_r[k-1];
      assign side_in = side_r[k-1];
    end

    always_comb begin
      for (int i = 0; i < E; i++) begin
        logic [C+1:0] r2;
        logic [C+1:0] d2;
        r2 = {rem_in[i], 1'b0};
        d2 = {1'b0, den_in[i]};
        if (r2 >= d2) begin
          rem_nxt[i] = (C+1)'(r2 - d2);
          quo_nxt[i] = {quo_in[i][T-2:0], 1'b1};
        end else begin
          rem_nxt[i] = r2[C:0];
          quo_nxt[i] = {quo_in[i][T-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en[k]) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_r[k]  <= rem_nxt;
        den_r[k]  <= den_in;
        quo_r[k]  <= quo_nxt;
        side_r[k] <= side_in;
      end
    end
  end

  assign out_valid = v_r[T-1];
  assign out_quo   = quo_r[T-1];
  assign out_side  = side_r[T-1];

endmodule
